// File: rtl/urx_pkg.sv
package urx_pkg;

    localparam int FIFO_DEPTH = 256;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int BT_W       = 16;
    localparam int DATA_W     = 8;
    localparam int FRAME_BITS = 10;
    localparam int STOP_POS   = 9;
    localparam int POS_W      = 4;

    typedef logic [FIFO_AW-1:0] fifo_ptr_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_POP  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t kind;
        logic       rx_level;
    } item_t;

    typedef enum logic {
        RX_IDLE,
        RX_FRAME
    } rx_state_t;

    typedef struct packed {
        logic              push;
        logic [DATA_W-1:0] data;
        logic              resync;
    } rx_evt_t;

    typedef struct packed {
        logic pop_valid;
        logic fifo_empty;
        logic byte_received;
        logic oldest_dropped;
        logic resynced;
    } res_flags_t;

    function automatic fifo_ptr_t ptr_inc(input fifo_ptr_t p);
        return (p == fifo_ptr_t'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// File: rtl/urx_front.sv
module urx_front
    import urx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  in_kind,
    input  logic  in_level,
    output logic  q_valid,
    output item_t q_item,
    input  logic  q_deq
);

    // two-entry queue decouples the port from the execute stage
    item_t       q_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        acc;

    assign s_tready = (count_reg != 2'd2);
    assign acc      = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = acc ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_deq ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, acc} - {1'b0, q_deq};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            q_mem[wr_ptr_reg] <= '{kind: item_kind_t'(in_kind), rx_level: in_level};
        end
    end

endmodule

// File: rtl/urx_rcv.sv
module urx_rcv
    import urx_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [BT_W-1:0] bit_ticks,
    input  logic            tick_en,
    input  logic            level,
    output rx_evt_t         evt
);

    rx_state_t             state_reg, state_next;
    logic [BT_W-1:0]       tick_reg, tick_next;
    logic [FRAME_BITS-1:0] cap_reg, cap_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic [BT_W-1:0]       full_p, half_raw, half_p, tc_inc;
    logic [POS_W-1:0]      pos_c, p_sel;
    logic [FRAME_BITS-1:0] cap_w;
    logic                  found;

    assign full_p   = (bit_ticks == '0) ? BT_W'(1) : bit_ticks;
    assign half_raw = bit_ticks >> 1;
    assign half_p   = (half_raw == '0) ? BT_W'(1) : half_raw;
    assign tc_inc   = tick_reg + 1'b1;
    assign pos_c    = (pos_reg > POS_W'(STOP_POS)) ? POS_W'(STOP_POS) : pos_reg;

    always_comb begin
        cap_w        = cap_reg;
        cap_w[pos_c] = level;
    end

    // lowest 1-then-0 pair wins
    always_comb begin
        found = 1'b0;
        p_sel = '0;
        for (int p = FRAME_BITS - 1; p >= 1; p--) begin
            if (cap_w[p-1] && !cap_w[p]) begin
                found = 1'b1;
                p_sel = POS_W'(p);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        tick_next  = tick_reg;
        cap_next   = cap_reg;
        pos_next   = pos_reg;
        evt        = '0;
        if (tick_en) begin
            tick_next = tc_inc;
            case (state_reg)
                RX_IDLE: begin
                    if (tc_inc >= half_p) begin
                        tick_next = '0;
                        if (!level) begin
                            state_next = RX_FRAME;
                            cap_next   = '0;
                            pos_next   = POS_W'(1);
                        end
                    end
                end
                RX_FRAME: begin
                    if (tc_inc >= full_p) begin
                        tick_next = '0;
                        cap_next  = cap_w;
                        pos_next  = pos_c + 1'b1;
                        if (pos_c == POS_W'(STOP_POS)) begin
                            if (cap_w[STOP_POS]) begin
                                evt.push   = 1'b1;
                                evt.data   = cap_w[DATA_W:1];
                                state_next = RX_IDLE;
                                pos_next   = '0;
                            end else if (found) begin
                                cap_next   = cap_w >> p_sel;
                                pos_next   = POS_W'(FRAME_BITS) - p_sel;
                                evt.resync = 1'b1;
                            end else begin
                                state_next = RX_IDLE;
                                pos_next   = '0;
                            end
                        end
                    end
                end
                default: begin
                    state_next = RX_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RX_IDLE;
            tick_reg  <= '0;
            cap_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            cap_reg   <= cap_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: rtl/urx_fifo.sv
module urx_fifo
    import urx_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop_en,
    output logic              pop_valid,
    output logic              dropped,
    output logic              empty_after,
    output logic [DATA_W-1:0] rd_data_reg
);

    logic [DATA_W-1:0] store [FIFO_DEPTH];
    fifo_ptr_t         head_reg, head_next;
    fifo_ptr_t         tail_reg, tail_next;
    fifo_ptr_t         tail_inc;
    logic              empty_now;

    assign empty_now = (head_reg == tail_reg);
    assign tail_inc  = ptr_inc(tail_reg);
    assign pop_valid = pop_en && !empty_now;
    assign dropped   = push && (tail_inc == head_reg);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (push) begin
            tail_next = tail_inc;
            if (dropped) begin
                head_next = ptr_inc(head_reg);
            end
        end else if (pop_valid) begin
            head_next = ptr_inc(head_reg);
        end
        empty_after = (head_next == tail_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // read data held until the next pop
    always_ff @(posedge aclk) begin
        if (push) begin
            store[tail_reg] <= push_data;
        end
        if (pop_valid) begin
            rd_data_reg <= store[head_reg];
        end
    end

`ifndef SYNTHESIS
    a_push_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (head_reg != tail_reg))
        else $error("fifo empty after a push");

    a_pop_empty_still: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_en && empty_now && !push) |=> ($stable(head_reg) && $stable(tail_reg)))
        else $error("pop on empty fifo moved a pointer");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_valid && !push) |=> (head_reg != $past(head_reg) && $stable(tail_reg)))
        else $error("pop did not advance head only");

    a_drop_keeps_full: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped |=> (ptr_inc(tail_reg) == head_reg))
        else $error("fifo not full after dropping oldest word");
`endif

endmodule

// File: rtl/uart_rx_resync_fifo.sv
// channel | dir | tvalid/tready       | tdata / tuser
// s_      | in  | s_tvalid, s_tready  | tdata[0] rx_level; tuser kind (0 tick, 1 pop)
// m_      | out | m_tvalid, m_tready  | tdata pop_valid, pop_byte, fifo_empty,
//         |     |                     |   byte_received, oldest_dropped, resynced
// cfg     | in  | cfg_wr_en           | cfg_wr_data bit_ticks
//
// One word per clock sustained while m_tready stays high; each accepted word passes
// through the input queue, then the execute stage with the registered fifo read port.
// Reset (aresetn low, synchronous) empties the queue and fifo and idles the receiver.
// Output stalls are absorbed by the two-entry input queue; s_tready drops once it fills.
module uart_rx_resync_fifo
    import urx_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [0] rx_level, [7:1] zero
    input  logic            s_tuser,   // [0] kind
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,   // [0] pop_valid, [8:1] pop_byte, [9] fifo_empty,
                                       // [10] byte_received, [11] oldest_dropped,
                                       // [12] resynced, [15:13] zero
    input  logic            cfg_wr_en,
    input  logic [BT_W-1:0] cfg_wr_data
);

    logic [BT_W-1:0]   bit_ticks_reg;
    logic              q_valid;
    item_t             q_item;
    logic              exec_fire;
    logic              tick_en, pop_en;
    rx_evt_t           evt;
    logic              pop_valid, dropped, empty_after;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] pop_byte;
    res_flags_t        flags_reg, flags_next;
    logic              m_tvalid_reg, m_tvalid_next;

    urx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_kind  (s_tuser),
        .in_level (s_tdata[0]),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_deq    (exec_fire)
    );

    assign exec_fire = q_valid && (!m_tvalid_reg || m_tready);
    assign tick_en   = exec_fire && (q_item.kind == KIND_TICK);
    assign pop_en    = exec_fire && (q_item.kind == KIND_POP);

    urx_rcv u_rcv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bit_ticks (bit_ticks_reg),
        .tick_en   (tick_en),
        .level     (q_item.rx_level),
        .evt       (evt)
    );

    urx_fifo u_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (evt.push),
        .push_data   (evt.data),
        .pop_en      (pop_en),
        .pop_valid   (pop_valid),
        .dropped     (dropped),
        .empty_after (empty_after),
        .rd_data_reg (rd_data)
    );

    always_comb begin
        flags_next.pop_valid      = pop_valid;
        flags_next.fifo_empty     = empty_after;
        flags_next.byte_received  = evt.push;
        flags_next.oldest_dropped = dropped;
        flags_next.resynced       = evt.resync;
        if (exec_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= BT_W'(16);
            m_tvalid_reg  <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                bit_ticks_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            flags_reg <= flags_next;
        end
    end

    assign pop_byte = flags_reg.pop_valid ? rd_data : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, flags_reg.resynced, flags_reg.oldest_dropped,
                       flags_reg.byte_received, flags_reg.fifo_empty, pop_byte,
                       flags_reg.pop_valid};

endmodule
